FILE: sv/btc_pkg.sv
// Shared widths, register indexes and the raw sample type for the barometric compensation block.
package btc_pkg;

  localparam int RAW_W  = 24;
  localparam int TEMP_W = 16;
  localparam int PRES_W = 24;
  localparam int CFG_DW = 64;
  localparam int CFG_AW = 5;

  // Trim register indexes, in register map order
  typedef enum logic [1:0] {
    REG_TRIM_T     = 2'd0,
    REG_TRIM_P_LO  = 2'd1,
    REG_TRIM_P_MID = 2'd2,
    REG_TRIM_P_HI  = 2'd3
  } reg_idx_t;

  typedef logic [RAW_W-1:0] raw_t;

endpackage

FILE: sv/btc_in_if.sv
// Request channel carrying one raw pressure and temperature sample pair.
interface btc_in_if;
  logic                valid;
  logic                ready;
  btc_pkg::raw_t       raw_pressure;
  btc_pkg::raw_t       raw_temperature;

  modport source (output valid, output raw_pressure, output raw_temperature, input ready);
  modport sink   (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

FILE: sv/btc_out_if.sv
// Request channel carrying one compensated temperature and pressure result.
interface btc_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [btc_pkg::TEMP_W-1:0] temperature;
  logic        [btc_pkg::PRES_W-1:0] pressure;

  modport source (output valid, output temperature, output pressure, input ready);
  modport sink   (input valid, input temperature, input pressure, output ready);
endinterface

FILE: sv/baro_trim_compensation.sv
// Throughput: one request per cycle unless the output stalls; ten register stages,
// the multipliers of the temperature powers and pressure polynomial spread over them,
// valid bits beside data. A stalled output freezes every stage, so nothing is lost
// or repeated. Reset (rst_n low, synchronous) clears all valid bits and all trim
// registers to zero.
module baro_trim_compensation #(
  parameter int TEMP_FRAC_BITS     = 8,
  parameter int PRESSURE_FRAC_BITS = 6
) (
  input  logic                        clk,
  input  logic                        rst_n,
  btc_in_if.sink                      in_chan,
  btc_out_if.source                   out_chan,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [btc_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [btc_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [btc_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready
);

  localparam int NST = 10;
  localparam int TSH = 48 - TEMP_FRAC_BITS;
  localparam int PSH = 32 - PRESSURE_FRAC_BITS;
  localparam logic signed [61:0] T_LO = -(62'sd40 <<< TEMP_FRAC_BITS);
  localparam logic signed [61:0] T_HI = 62'sd85 <<< TEMP_FRAC_BITS;
  localparam logic signed [61:0] T_CL = 62'sd1 <<< 24;
  localparam logic signed [57:0] P_HI = (58'sd1 <<< btc_pkg::PRES_W) - 58'sd1;
  localparam logic signed [17:0] K_OFS = 18'sd16384;

  // Trim registers
  logic [39:0] trim_t_r;
  logic [47:0] trim_plo_r, trim_pmid_r;
  logic [31:0] trim_phi_r;
  btc_pkg::reg_idx_t cfg_idx;
  logic cfg_wr;

  assign cfg_idx    = btc_pkg::reg_idx_t'(cfg_paddr[4:3]);
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;

  // Write trim registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trim_t_r    <= '0;
      trim_plo_r  <= '0;
      trim_pmid_r <= '0;
      trim_phi_r  <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        btc_pkg::REG_TRIM_T:     trim_t_r    <= cfg_pwdata[39:0];
        btc_pkg::REG_TRIM_P_LO:  trim_plo_r  <= cfg_pwdata[47:0];
        btc_pkg::REG_TRIM_P_MID: trim_pmid_r <= cfg_pwdata[47:0];
        btc_pkg::REG_TRIM_P_HI:  trim_phi_r  <= cfg_pwdata[31:0];
        default: ;
      endcase
    end
  end

  // Read back trim registers
  always_comb begin
    case (cfg_idx)
      btc_pkg::REG_TRIM_T:     cfg_prdata = {24'h0, trim_t_r};
      btc_pkg::REG_TRIM_P_LO:  cfg_prdata = {16'h0, trim_plo_r};
      btc_pkg::REG_TRIM_P_MID: cfg_prdata = {16'h0, trim_pmid_r};
      btc_pkg::REG_TRIM_P_HI:  cfg_prdata = {32'h0, trim_phi_r};
      default:                 cfg_prdata = '0;
    endcase
  end

  // Unpack trim fields
  logic        [15:0] t1, t2c, p5, p6;
  logic signed [7:0]  t3c, p3, p4, p7, p8, p10, p11;
  logic signed [15:0] p1, p2, p9;
  assign t1  = trim_t_r[15:0];
  assign t2c = trim_t_r[31:16];
  assign t3c = $signed(trim_t_r[39:32]);
  assign p1  = $signed(trim_plo_r[15:0]);
  assign p2  = $signed(trim_plo_r[31:16]);
  assign p3  = $signed(trim_plo_r[39:32]);
  assign p4  = $signed(trim_plo_r[47:40]);
  assign p5  = trim_pmid_r[15:0];
  assign p6  = trim_pmid_r[31:16];
  assign p7  = $signed(trim_pmid_r[39:32]);
  assign p8  = $signed(trim_pmid_r[47:40]);
  assign p9  = $signed(trim_phi_r[15:0]);
  assign p10 = $signed(trim_phi_r[23:16]);
  assign p11 = $signed(trim_phi_r[31:24]);

  // Stall control: every stage advances when the output slot is free or taken
  logic [NST-1:0] vld_r;
  logic en;
  assign en            = ~vld_r[NST-1] | out_chan.ready;
  assign in_chan.ready = en;
  assign out_chan.valid = vld_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_chan.valid};
    end
  end

  // Stage registers
  logic        [23:0] up1_r, up2_r, up3_r, up4_r, up5_r, up6_r, up7_r;
  logic signed [25:0] d1_r;
  logic signed [42:0] pdt2_r;
  logic signed [51:0] dd2_r;
  logic        [47:0] u2_2_r, u2_3_r, u2_4_r;
  logic signed [61:0] tq3_r;
  logic signed [15:0] tmp4_r, tmp5_r, tmp6_r, tmp7_r, tmp8_r, tmp9_r, tmp10_r;
  logic signed [25:0] t4_r, t5_r;
  logic signed [39:0] u2p4_r;
  logic signed [33:0] tt2_5_r;
  logic signed [34:0] c5_r;
  logic signed [63:0] cubp5_r;
  logic        [23:0] a5_r, b5_r;
  logic signed [41:0] tt3_6_r;
  logic signed [39:0] sa6_r, sens7_r;
  logic signed [54:0] offa6_r, off7_r;
  logic signed [51:0] ac6_r;
  logic signed [27:0] bc6_r;
  logic signed [47:0] cube6_r, cube7_r;
  logic signed [52:0] quad7_r;
  logic signed [55:0] mul8_r;
  logic signed [56:0] sum8_r;
  logic signed [57:0] acc9_r;
  logic        [23:0] pres10_r;

  // Stage 1..3: temperature quadratic
  logic signed [25:0] d1_nxt;
  logic signed [42:0] pdt2_nxt;
  logic signed [51:0] dd2_nxt;
  logic signed [61:0] tq3_nxt;
  always_comb begin
    d1_nxt   = $signed({2'b00, in_chan.raw_temperature}) - $signed({2'b00, t1, 8'h00});
    pdt2_nxt = d1_r * $signed({1'b0, t2c});
    dd2_nxt  = d1_r * d1_r;
    tq3_nxt  = (pdt2_r <<< 18) + dd2_r * t3c;
  end

  // Stage 4: round and clamp temperature, scale cube term
  logic signed [61:0] trt, tr16, tmpc, t4c;
  logic signed [56:0] mp11, rp11;
  logic signed [15:0] tmp4_nxt;
  logic signed [25:0] t4_nxt;
  logic signed [39:0] u2p4_nxt;
  always_comb begin
    trt  = (tq3_r + (62'sd1 <<< (TSH - 1))) >>> TSH;
    tmpc = (trt < T_LO) ? T_LO : ((trt > T_HI) ? T_HI : trt);
    tmp4_nxt = tmpc[15:0];
    tr16 = (tq3_r + (62'sd1 <<< 31)) >>> 32;
    t4c  = (tr16 < -T_CL) ? -T_CL : ((tr16 > T_CL) ? T_CL : tr16);
    t4_nxt = t4c[25:0];
    mp11 = $signed({1'b0, u2_3_r}) * p11;
    rp11 = (mp11 + 57'sd65536) >>> 17;
    u2p4_nxt = rp11[39:0];
  end

  // Stage 5: temperature square, quadratic coefficient, cube product
  logic signed [51:0] tsq, rtsq;
  logic signed [33:0] tt2_5_nxt;
  logic signed [34:0] c5_nxt;
  logic signed [63:0] cubp5_nxt;
  always_comb begin
    tsq       = t4_r * t4_r;
    rtsq      = (tsq + 52'sd32768) >>> 16;
    tt2_5_nxt = rtsq[33:0];
    c5_nxt    = (35'(p9) <<< 16) + p10 * t4_r;
    cubp5_nxt = $signed({1'b0, up4_r}) * u2p4_r;
  end

  // Stage 6: temperature cube, partial sensitivity, offset and quadratic terms
  logic signed [59:0] mt3, rt3;
  logic signed [17:0] p1m, p2m;
  logic signed [43:0] mp2, rp2;
  logic signed [41:0] mp3, rp3;
  logic signed [42:0] mo6;
  logic signed [41:0] mo7;
  logic signed [59:0] mac, rac, mbc, rbc;
  logic signed [63:0] rcub;
  logic signed [41:0] tt3_6_nxt;
  logic signed [39:0] sa6_nxt;
  logic signed [54:0] offa6_nxt;
  logic signed [51:0] ac6_nxt;
  logic signed [27:0] bc6_nxt;
  logic signed [47:0] cube6_nxt;
  always_comb begin
    mt3       = tt2_5_r * t5_r;
    rt3       = (mt3 + 60'sd32768) >>> 16;
    tt3_6_nxt = rt3[41:0];
    p1m = 18'(p1) - K_OFS;
    p2m = 18'(p2) - K_OFS;
    mp2 = p2m * t5_r;
    rp2 = (mp2 + 44'sd16) >>> 5;
    mp3 = p3 * tt2_5_r;
    rp3 = (mp3 + 42'sd128) >>> 8;
    sa6_nxt = (40'(p1m) <<< 20) + 40'(rp2) + 40'(rp3);
    mo6 = $signed({1'b0, p6}) * t5_r;
    mo7 = p7 * tt2_5_r;
    offa6_nxt = (55'($signed({1'b0, p5})) <<< 35)
              + (55'(mo6) <<< 10)
              + (55'(mo7) <<< 8);
    mac = $signed({1'b0, a5_r}) * c5_r;
    rac = (mac + 60'sd128) >>> 8;
    ac6_nxt = rac[51:0];
    mbc = $signed({1'b0, b5_r}) * c5_r;
    rbc = (mbc + (60'sd1 <<< 31)) >>> 32;
    bc6_nxt = rbc[27:0];
    rcub = (cubp5_r + 64'sd32768) >>> 16;
    cube6_nxt = rcub[47:0];
  end

  // Stage 7: finish sensitivity, offset and quadratic term
  logic signed [49:0] mp4, rp4, mo8;
  logic signed [39:0] sens7_nxt;
  logic signed [54:0] off7_nxt;
  logic signed [52:0] quad7_nxt;
  always_comb begin
    mp4       = p4 * tt3_6_r;
    rp4       = (mp4 + 50'sd4096) >>> 13;
    sens7_nxt = sa6_r + 40'(rp4);
    mo8       = p8 * tt3_6_r;
    off7_nxt  = offa6_r + (55'(mo8) <<< 1);
    quad7_nxt = 53'(ac6_r) + 53'(bc6_r);
  end

  // Stage 8: raw pressure times sensitivity, sum of the other terms
  logic signed [63:0] msn, rsn;
  logic signed [55:0] mul8_nxt;
  logic signed [56:0] sum8_nxt;
  always_comb begin
    msn      = $signed({1'b0, up7_r}) * sens7_r;
    rsn      = (msn + 64'sd128) >>> 8;
    mul8_nxt = rsn[55:0];
    sum8_nxt = 57'(off7_r) + 57'(quad7_r) + 57'(cube7_r);
  end

  // Stage 9..10: accumulate, round and saturate pressure
  logic signed [57:0] acc9_nxt, racc;
  logic        [23:0] pres10_nxt;
  always_comb begin
    acc9_nxt = 58'(sum8_r) + 58'(mul8_r);
    racc     = (acc9_r + (58'sd1 <<< (PSH - 1))) >>> PSH;
    if (racc < 58'sd0) begin
      pres10_nxt = '0;
    end else if (racc > P_HI) begin
      pres10_nxt = '1;
    end else begin
      pres10_nxt = racc[23:0];
    end
  end

  // Advance payload through the stages
  always_ff @(posedge clk) begin
    if (en) begin
      up1_r   <= in_chan.raw_pressure;
      d1_r    <= d1_nxt;
      up2_r   <= up1_r;
      pdt2_r  <= pdt2_nxt;
      dd2_r   <= dd2_nxt;
      u2_2_r  <= up1_r * up1_r;
      up3_r   <= up2_r;
      tq3_r   <= tq3_nxt;
      u2_3_r  <= u2_2_r;
      up4_r   <= up3_r;
      tmp4_r  <= tmp4_nxt;
      t4_r    <= t4_nxt;
      u2p4_r  <= u2p4_nxt;
      u2_4_r  <= u2_3_r;
      up5_r   <= up4_r;
      tmp5_r  <= tmp4_r;
      t5_r    <= t4_r;
      tt2_5_r <= tt2_5_nxt;
      c5_r    <= c5_nxt;
      cubp5_r <= cubp5_nxt;
      a5_r    <= u2_4_r[47:24];
      b5_r    <= u2_4_r[23:0];
      up6_r   <= up5_r;
      tmp6_r  <= tmp5_r;
      tt3_6_r <= tt3_6_nxt;
      sa6_r   <= sa6_nxt;
      offa6_r <= offa6_nxt;
      ac6_r   <= ac6_nxt;
      bc6_r   <= bc6_nxt;
      cube6_r <= cube6_nxt;
      up7_r   <= up6_r;
      tmp7_r  <= tmp6_r;
      sens7_r <= sens7_nxt;
      off7_r  <= off7_nxt;
      quad7_r <= quad7_nxt;
      cube7_r <= cube6_r;
      tmp8_r  <= tmp7_r;
      mul8_r  <= mul8_nxt;
      sum8_r  <= sum8_nxt;
      tmp9_r  <= tmp8_r;
      acc9_r  <= acc9_nxt;
      tmp10_r <= tmp9_r;
      pres10_r <= pres10_nxt;
    end
  end

  assign out_chan.temperature = tmp10_r;
  assign out_chan.pressure    = pres10_r;

endmodule

FILE: sv/btc_checker.sv
// Port-level checks of the compensation block's request channels, bound to the top level.
module btc_port_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);

  // Hold a pending result until it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // Drop all results after reset
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

  // Accept requests exactly when the output slot frees up
  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output stall");

endmodule

bind baro_trim_compensation btc_port_checker u_btc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready)
);
